>>> rtl/fpca_pkg.sv
// Shared codes, field widths and types of the fit-policy chunk allocator.
package fpca_pkg;

  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 4;
  localparam int FIELD_W  = 16;
  localparam int POLICY_W = 2;
  localparam int COUNT_W  = 5;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;
  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 40;

  localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_REQUEST = 2'd2;

  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  // register index is paddr[2]
  localparam logic REG_FIT_POLICY  = 1'b0;
  localparam logic REG_CHUNK_COUNT = 1'b1;

  localparam logic [POLICY_W-1:0] POLICY_RESET = POL_FIRST;
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_SCAN,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic                clear;
    logic                sample;
    logic [POLICY_W-1:0] policy;
  } pick_ctl_t;

endpackage

>>> rtl/fit_policy_chunk_allocator.sv
// Top level of the fit-policy chunk allocator: config port, sequencer and memories.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------
//  in_      | slave     | tvalid/tready      | tuser opcode, tdata index + size
//  out_     | master    | tvalid/tready      | tuser assigned, tdata chunk/orig/echo
//  cfg_     | APB slave | psel/penable/pready| fit_policy at 0x0, chunk_count at 0x4
//
// A load is written without leaving idle. A restart sweeps every chunk, original to
// remaining. A request scans min(chunk_count, CHUNKS) chunks, one per cycle through
// the read port of both memories.
// A result waits in the output register; a request only stalls at its end when
// the previous result is still not taken. Reset clears control only; chunk sizes
// are undefined until loaded.
module fit_policy_chunk_allocator #(
  parameter int CHUNKS    = 16,
  parameter int SIZE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: chunk_index[3:0], size_value[19:4], zero pad [23:20]
  input  logic [fpca_pkg::IN_DW-1:0]    in_tdata,
  // in_tuser: opcode[1:0]
  input  logic [fpca_pkg::OPCODE_W-1:0] in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // out_tdata: chosen_chunk[3:0], chunk_original_size[19:4], request_echo[35:20], pad
  output logic [fpca_pkg::OUT_DW-1:0]   out_tdata,
  // out_tuser: assigned[0]
  output logic                          out_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [fpca_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [fpca_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [fpca_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int IDX_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int CNT_W = $clog2(CHUNKS + 1);

  // configuration
  logic [fpca_pkg::POLICY_W-1:0] policy_r;
  logic [fpca_pkg::COUNT_W-1:0]  count_r;
  logic                          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= fpca_pkg::POLICY_RESET;
      count_r  <= fpca_pkg::COUNT_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        fpca_pkg::REG_FIT_POLICY:  policy_r <= cfg_pwdata[fpca_pkg::POLICY_W-1:0];
        fpca_pkg::REG_CHUNK_COUNT: count_r  <= cfg_pwdata[fpca_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      fpca_pkg::REG_FIT_POLICY:  cfg_prdata = fpca_pkg::APB_DW'(policy_r);
      fpca_pkg::REG_CHUNK_COUNT: cfg_prdata = fpca_pkg::APB_DW'(count_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // input fields
  logic [fpca_pkg::OPCODE_W-1:0] in_opcode;
  logic [fpca_pkg::INDEX_W-1:0]  in_index;
  logic [SIZE_BITS-1:0]          in_size;
  logic                          in_acc;
  logic                          load_ok;

  assign in_opcode = in_tuser;
  assign in_index  = in_tdata[fpca_pkg::INDEX_W-1:0];
  assign in_size   = SIZE_BITS'(in_tdata[fpca_pkg::INDEX_W +: fpca_pkg::FIELD_W]);
  assign in_acc    = in_tvalid && in_tready;
  assign load_ok   = 32'(in_index) < CHUNKS;

  // sequencer state
  fpca_pkg::state_t     state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     limit_r, limit_nxt;
  logic [SIZE_BITS-1:0] req_r, req_nxt;
  logic                 rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 issue;

  // memory ports
  logic                 orig_we;
  logic                 rem_we;
  logic [IDX_W-1:0]     rem_waddr;
  logic [SIZE_BITS-1:0] rem_wdata;
  logic [IDX_W-1:0]     rd_addr;
  logic [SIZE_BITS-1:0] orig_rdata;
  logic [SIZE_BITS-1:0] rem_rdata;

  // selection
  fpca_pkg::pick_ctl_t  pick_ctl;
  logic                 found;
  logic [IDX_W-1:0]     pick_idx;
  logic [SIZE_BITS-1:0] pick_rem;
  logic [SIZE_BITS-1:0] pick_orig;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_load;
  logic                          out_assigned_r;
  logic [fpca_pkg::INDEX_W-1:0]  out_chunk_r;
  logic [fpca_pkg::FIELD_W-1:0]  out_orig_r;
  logic [fpca_pkg::FIELD_W-1:0]  out_echo_r;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    limit_nxt       = limit_r;
    req_nxt         = req_r;
    rd_pend_nxt     = 1'b0;
    rd_idx_nxt      = rd_idx_r;
    issue           = 1'b0;
    in_tready       = 1'b0;
    orig_we         = 1'b0;
    rem_we          = 1'b0;
    rem_waddr       = IDX_W'(in_index);
    rem_wdata       = in_size;
    rd_addr         = cnt_r[IDX_W-1:0];
    pick_ctl        = '0;
    pick_ctl.policy = policy_r;
    out_load        = 1'b0;

    case (state_r)
      fpca_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          case (in_opcode)
            fpca_pkg::OP_LOAD: begin
              orig_we = load_ok;
              rem_we  = load_ok;
            end
            fpca_pkg::OP_RESTART: begin
              cnt_nxt   = '0;
              state_nxt = fpca_pkg::ST_COPY;
            end
            fpca_pkg::OP_REQUEST: begin
              req_nxt = in_size;
              if (32'(count_r) > CHUNKS) begin
                limit_nxt = CNT_W'(CHUNKS);
              end else begin
                limit_nxt = CNT_W'(count_r);
              end
              cnt_nxt        = '0;
              pick_ctl.clear = 1'b1;
              state_nxt      = fpca_pkg::ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      fpca_pkg::ST_COPY: begin
        issue = cnt_r < CNT_W'(CHUNKS);
        if (issue) begin
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = cnt_r[IDX_W-1:0];
          cnt_nxt     = cnt_r + CNT_W'(1);
        end
        // read data of the previous cycle goes straight back into remaining
        rem_we    = rd_pend_r;
        rem_waddr = rd_idx_r;
        rem_wdata = orig_rdata;
        if (!issue && !rd_pend_r) begin
          state_nxt = fpca_pkg::ST_IDLE;
        end
      end
      fpca_pkg::ST_SCAN: begin
        issue = cnt_r < limit_r;
        if (issue) begin
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = cnt_r[IDX_W-1:0];
          cnt_nxt     = cnt_r + CNT_W'(1);
        end
        pick_ctl.sample = rd_pend_r;
        if (!issue && !rd_pend_r) begin
          state_nxt = fpca_pkg::ST_WRITE;
        end
      end
      fpca_pkg::ST_WRITE: begin
        if (!out_valid_r || out_tready) begin
          rem_we    = found;
          rem_waddr = pick_idx;
          rem_wdata = pick_rem - req_r;
          out_load  = 1'b1;
          state_nxt = fpca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fpca_pkg::ST_IDLE;
      end
    endcase

    out_valid_nxt = (out_valid_r && !out_tready) || out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpca_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    limit_r  <= limit_nxt;
    req_r    <= req_nxt;
    rd_idx_r <= rd_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_assigned_r <= found;
      out_chunk_r    <= found ? fpca_pkg::INDEX_W'(pick_idx) : '0;
      out_orig_r     <= found ? fpca_pkg::FIELD_W'(pick_orig) : '0;
      out_echo_r     <= fpca_pkg::FIELD_W'(req_r);
    end
  end

  fpca_ram #(
    .DEPTH  (CHUNKS),
    .ADDR_W (IDX_W),
    .DATA_W (SIZE_BITS)
  ) u_orig_ram (
    .clk   (clk),
    .we    (orig_we),
    .waddr (IDX_W'(in_index)),
    .wdata (in_size),
    .raddr (rd_addr),
    .rdata (orig_rdata)
  );

  fpca_ram #(
    .DEPTH  (CHUNKS),
    .ADDR_W (IDX_W),
    .DATA_W (SIZE_BITS)
  ) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (rd_addr),
    .rdata (rem_rdata)
  );

  fpca_pick #(
    .IDX_W  (IDX_W),
    .SIZE_W (SIZE_BITS)
  ) u_pick (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (pick_ctl),
    .req_size  (req_r),
    .cand_idx  (rd_idx_r),
    .cand_rem  (rem_rdata),
    .cand_orig (orig_rdata),
    .found     (found),
    .pick_idx  (pick_idx),
    .pick_rem  (pick_rem),
    .pick_orig (pick_orig)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_assigned_r;
  assign out_tdata  = {4'b0000, out_echo_r, out_orig_r, out_chunk_r};

endmodule

>>> rtl/fpca_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module fpca_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/fpca_pick.sv
// Running fit selection over the chunks streamed out of the size memories.
module fpca_pick #(
  parameter int IDX_W  = 4,
  parameter int SIZE_W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fpca_pkg::pick_ctl_t ctl,
  input  logic [SIZE_W-1:0]   req_size,
  input  logic [IDX_W-1:0]    cand_idx,
  input  logic [SIZE_W-1:0]   cand_rem,
  input  logic [SIZE_W-1:0]   cand_orig,
  output logic                found,
  output logic [IDX_W-1:0]    pick_idx,
  output logic [SIZE_W-1:0]   pick_rem,
  output logic [SIZE_W-1:0]   pick_orig
);

  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  idx_r;
  logic [SIZE_W-1:0] rem_r;
  logic [SIZE_W-1:0] orig_r;
  logic              fits;
  logic              better;
  logic              take;

  assign fits = cand_rem >= req_size;

  always_comb begin
    case (ctl.policy)
      fpca_pkg::POL_BEST:  better = cand_rem < rem_r;
      fpca_pkg::POL_WORST: better = cand_rem > rem_r;
      default:             better = 1'b0;
    endcase
  end

  // strict compares keep ties on the lowest index
  assign take = ctl.sample && fits && (!found_r || better);

  always_comb begin
    found_nxt = found_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      idx_r  <= cand_idx;
      rem_r  <= cand_rem;
      orig_r <= cand_orig;
    end
  end

  assign found     = found_r;
  assign pick_idx  = idx_r;
  assign pick_rem  = rem_r;
  assign pick_orig = orig_r;

endmodule

>>> rtl/fpca_checker.sv
// Port-level checks of the fit-policy chunk allocator, bound to the top level.
module fpca_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic [fpca_pkg::OPCODE_W-1:0] in_tuser,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [fpca_pkg::OUT_DW-1:0]   out_tdata,
  input logic                          out_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a refusal names no chunk and no size
  a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[19:0] == 20'd0)
    else $error("refused result carries chunk data");

  // a request occupies the block for at least the following cycle
  a_request_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == fpca_pkg::OP_REQUEST |=> !in_tready)
    else $error("request accepted back to back");

  // a load finishes in its own cycle
  a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == fpca_pkg::OP_LOAD |=> in_tready)
    else $error("load stalled the input");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid out of reset");

endmodule

bind fit_policy_chunk_allocator fpca_checker u_fpca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tuser   (in_tuser),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

>>> dv/fit_policy_chunk_allocator_tb.sv
// Self-checking testbench of the fit-policy chunk allocator: directed table, then random phases.
`timescale 1ns / 1ps

module fit_policy_chunk_allocator_tb;

  localparam int CHUNKS     = 16;
  localparam int DIR_N      = 24;
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 100;
  localparam int SETTLE_CYC = 40;   // longer than a restart sweep or a full scan
  localparam logic [fpca_pkg::APB_AW-1:0] ADDR_POLICY = {fpca_pkg::REG_FIT_POLICY, 2'b00};
  localparam logic [fpca_pkg::APB_AW-1:0] ADDR_COUNT  = {fpca_pkg::REG_CHUNK_COUNT, 2'b00};
  // opcode with no meaning; the block must ignore it
  localparam logic [fpca_pkg::OPCODE_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic                          assigned;
    logic [fpca_pkg::INDEX_W-1:0]  chunk;
    logic [fpca_pkg::FIELD_W-1:0]  orig;
    logic [fpca_pkg::FIELD_W-1:0]  echo;
  } grant_t;

  typedef struct packed {
    logic [fpca_pkg::OPCODE_W-1:0] op;
    logic [fpca_pkg::INDEX_W-1:0]  idx;
    logic [fpca_pkg::FIELD_W-1:0]  size;
    logic                          typed;
    logic                          assigned;
    logic [fpca_pkg::INDEX_W-1:0]  chunk;
    logic [fpca_pkg::FIELD_W-1:0]  orig;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic [fpca_pkg::IN_DW-1:0]    in_tdata = '0;
  logic [fpca_pkg::OPCODE_W-1:0] in_tuser = '0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [fpca_pkg::OUT_DW-1:0]   out_tdata;
  logic                          out_tuser;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic                          cfg_psel = 1'b0;
  logic                          cfg_penable = 1'b0;
  logic                          cfg_pwrite = 1'b0;
  logic [fpca_pkg::APB_AW-1:0]   cfg_paddr = '0;
  logic [fpca_pkg::APB_DW-1:0]   cfg_pwdata = '0;
  logic [fpca_pkg::APB_DW-1:0]   cfg_prdata;
  logic                          cfg_pready;

  // predictor state
  logic [fpca_pkg::FIELD_W-1:0]  chunk_orig [CHUNKS];
  logic [fpca_pkg::FIELD_W-1:0]  chunk_left [CHUNKS];
  logic [fpca_pkg::POLICY_W-1:0] pol_cfg;
  logic [fpca_pkg::COUNT_W-1:0]  cnt_cfg;

  grant_t   grant_q [$];
  dir_row_t dir_tab [DIR_N];
  int       err_cnt = 0;
  int       sender_pct = 0;
  int       recv_pct = 0;

  fit_policy_chunk_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("fit_policy_chunk_allocator verification failed");
    $finish;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_pct);
  end

  // Apply one item to the predicted chunk table; has is set for requests only.
  task automatic apply_item(input logic [fpca_pkg::OPCODE_W-1:0] op,
                            input logic [fpca_pkg::INDEX_W-1:0] idx,
                            input logic [fpca_pkg::FIELD_W-1:0] size,
                            output bit has, output grant_t g);
    int  lim;
    int  pick;
    bit  found;
    bit  done;
    has = 1'b0;
    g = '0;
    case (op)
      fpca_pkg::OP_LOAD: begin
        chunk_orig[idx] = size;
        chunk_left[idx] = size;
      end
      fpca_pkg::OP_RESTART: begin
        for (int k = 0; k < CHUNKS; k++) chunk_left[k] = chunk_orig[k];
      end
      fpca_pkg::OP_REQUEST: begin
        lim = (cnt_cfg > CHUNKS) ? CHUNKS : cnt_cfg;
        found = 1'b0;
        done = 1'b0;
        pick = 0;
        for (int j = 0; j < lim && !done; j++) begin
          if (chunk_left[j] >= size) begin
            if (!found) begin
              found = 1'b1;
              pick = j;
              // first fit, and the unused policy code, stop at the first hit
              if (pol_cfg != fpca_pkg::POL_BEST && pol_cfg != fpca_pkg::POL_WORST)
                done = 1'b1;
            end else if ((pol_cfg == fpca_pkg::POL_BEST &&
                          chunk_left[j] < chunk_left[pick]) ||
                         (pol_cfg == fpca_pkg::POL_WORST &&
                          chunk_left[j] > chunk_left[pick])) begin
              pick = j;
            end
          end
        end
        if (found) begin
          chunk_left[pick] = chunk_left[pick] - size;
          g.assigned = 1'b1;
          g.chunk = pick[fpca_pkg::INDEX_W-1:0];
          g.orig = chunk_orig[pick];
        end
        g.echo = size;
        has = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [fpca_pkg::OPCODE_W-1:0] op,
                           input logic [fpca_pkg::INDEX_W-1:0] idx,
                           input logic [fpca_pkg::FIELD_W-1:0] size, input bit typed,
                           input grant_t typed_g);
    int     gap;
    bit     has;
    grant_t g;
    gap = 0;
    while ($urandom_range(99) < sender_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {{(fpca_pkg::IN_DW-fpca_pkg::INDEX_W-fpca_pkg::FIELD_W){1'b0}}, size, idx};
    do @(posedge clk); while (!in_tready);
    apply_item(op, idx, size, has, g);
    if (has) grant_q.push_back(typed ? typed_g : g);
  endtask

  task automatic cfg_write(input logic [fpca_pkg::APB_AW-1:0] addr,
                           input logic [fpca_pkg::APB_DW-1:0] val);
    @(negedge clk);
    in_tvalid <= 1'b0;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr[2] == fpca_pkg::REG_FIT_POLICY) pol_cfg = val[fpca_pkg::POLICY_W-1:0];
    else cnt_cfg = val[fpca_pkg::COUNT_W-1:0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic wait_idle;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic logic [fpca_pkg::FIELD_W-1:0] rand_chunk_size;
    int r;
    r = $urandom_range(99);
    if (r < 25) return fpca_pkg::FIELD_W'($urandom_range(3, 1) * 256);   // equal sizes for ties
    if (r < 60) return fpca_pkg::FIELD_W'($urandom_range(1023));
    if (r < 85) return fpca_pkg::FIELD_W'($urandom);
    if (r < 92) return '0;
    return '1;
  endfunction

  function automatic logic [fpca_pkg::FIELD_W-1:0] rand_request_size;
    int r;
    int j;
    r = $urandom_range(99);
    j = $urandom_range(CHUNKS-1);
    if (r < 35) return fpca_pkg::FIELD_W'($urandom_range(63));
    if (r < 60) return fpca_pkg::FIELD_W'($urandom_range(1023));
    if (r < 75) return fpca_pkg::FIELD_W'($urandom);
    if (r < 88) return chunk_left[j];           // exact fit
    if (r < 95) return chunk_left[j] + 1'b1;    // just too large
    return '0;
  endfunction

  function automatic dir_row_t mk_row(input logic [fpca_pkg::OPCODE_W-1:0] op, input int idx,
                                      input int size, input bit typed, input bit a,
                                      input int c, input int o);
    dir_row_t row;
    row.op = op;
    row.idx = fpca_pkg::INDEX_W'(idx);
    row.size = fpca_pkg::FIELD_W'(size);
    row.typed = typed;
    row.assigned = a;
    row.chunk = fpca_pkg::INDEX_W'(c);
    row.orig = fpca_pkg::FIELD_W'(o);
    return row;
  endfunction

  task automatic check_field(input string name, input logic [fpca_pkg::FIELD_W-1:0] exp_v,
                             input logic [fpca_pkg::FIELD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_tvalid && out_tready) begin
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tuser %0b tdata 0x%0h",
                 $time, out_tuser, out_tdata);
        err_cnt++;
      end else begin
        g = grant_q.pop_front();
        check_field("assigned", fpca_pkg::FIELD_W'(g.assigned),
                    fpca_pkg::FIELD_W'(out_tuser));
        check_field("chosen_chunk", fpca_pkg::FIELD_W'(g.chunk),
                    fpca_pkg::FIELD_W'(out_tdata[3:0]));
        check_field("chunk_original_size", g.orig, out_tdata[19:4]);
        check_field("request_echo", g.echo, out_tdata[35:20]);
      end
    end
  end

  initial begin
    int       ph_pol [PHASES];
    int       ph_cnt [PHASES];
    int       r;
    int       guard;
    grant_t   tg;
    dir_row_t row;

    ph_pol = '{1, 2, 0, 3, 1, 2, 1, 2, 0, 1, 2, 3};
    ph_cnt = '{16, 16, 1, 16, 0, 31, 7, 3, 16, 17, 16, 9};

    dir_tab[0]  = mk_row(fpca_pkg::OP_LOAD, 0, 100, 0, 0, 0, 0);
    dir_tab[1]  = mk_row(fpca_pkg::OP_LOAD, 1, 50, 0, 0, 0, 0);
    dir_tab[2]  = mk_row(fpca_pkg::OP_LOAD, 2, 300, 0, 0, 0, 0);
    dir_tab[3]  = mk_row(fpca_pkg::OP_LOAD, 3, 0, 0, 0, 0, 0);
    dir_tab[4]  = mk_row(fpca_pkg::OP_LOAD, 4, 200, 0, 0, 0, 0);
    dir_tab[5]  = mk_row(fpca_pkg::OP_LOAD, 5, 65535, 0, 0, 0, 0);
    dir_tab[6]  = mk_row(fpca_pkg::OP_LOAD, 6, 150, 0, 0, 0, 0);
    dir_tab[7]  = mk_row(fpca_pkg::OP_LOAD, 7, 400, 0, 0, 0, 0);
    dir_tab[8]  = mk_row(fpca_pkg::OP_LOAD, 8, 10, 0, 0, 0, 0);
    dir_tab[9]  = mk_row(fpca_pkg::OP_LOAD, 9, 20, 0, 0, 0, 0);
    dir_tab[10] = mk_row(fpca_pkg::OP_LOAD, 10, 30, 0, 0, 0, 0);
    dir_tab[11] = mk_row(fpca_pkg::OP_LOAD, 11, 40, 0, 0, 0, 0);
    dir_tab[12] = mk_row(fpca_pkg::OP_LOAD, 12, 60, 0, 0, 0, 0);
    dir_tab[13] = mk_row(fpca_pkg::OP_LOAD, 13, 70, 0, 0, 0, 0);
    dir_tab[14] = mk_row(fpca_pkg::OP_LOAD, 14, 80, 0, 0, 0, 0);
    dir_tab[15] = mk_row(fpca_pkg::OP_LOAD, 15, 90, 0, 0, 0, 0);
    // reset config: first fit over all chunks
    dir_tab[16] = mk_row(fpca_pkg::OP_REQUEST, 0, 0, 1, 1, 0, 100);        // zero size
    dir_tab[17] = mk_row(fpca_pkg::OP_REQUEST, 15, 65535, 1, 1, 5, 65535); // index ignored
    dir_tab[18] = mk_row(fpca_pkg::OP_REQUEST, 0, 65535, 1, 0, 0, 0);      // refused
    dir_tab[19] = mk_row(fpca_pkg::OP_REQUEST, 0, 100, 1, 1, 0, 100);      // exact fit
    dir_tab[20] = mk_row(fpca_pkg::OP_REQUEST, 0, 120, 1, 1, 2, 300);
    dir_tab[21] = mk_row(OP_SPARE, 7, 65535, 0, 0, 0, 0);                  // unused opcode
    dir_tab[22] = mk_row(fpca_pkg::OP_RESTART, 0, 0, 0, 0, 0, 0);
    dir_tab[23] = mk_row(fpca_pkg::OP_REQUEST, 0, 65535, 1, 1, 5, 65535);

    for (int k = 0; k < CHUNKS; k++) begin
      chunk_orig[k] = '0;
      chunk_left[k] = '0;
    end
    pol_cfg = fpca_pkg::POLICY_RESET;
    cnt_cfg = fpca_pkg::COUNT_RESET;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < DIR_N; k++) begin
      row = dir_tab[k];
      tg.assigned = row.assigned;
      tg.chunk = row.chunk;
      tg.orig = row.orig;
      tg.echo = row.size;
      send_item(row.op, row.idx, row.size, row.typed, tg);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      cfg_write(ADDR_POLICY, fpca_pkg::APB_DW'(ph_pol[p]));
      cfg_write(ADDR_COUNT, fpca_pkg::APB_DW'(ph_cnt[p]));
      case (p % 4)
        0: begin sender_pct = 0;  recv_pct = 0;  end
        1: begin sender_pct = 71; recv_pct = 0;  end
        2: begin sender_pct = 0;  recv_pct = 71; end
        default: begin sender_pct = 15; recv_pct = 15; end
      endcase
      tg = '0;
      // fresh table so every scanned chunk holds a loaded size
      for (int k = 0; k < CHUNKS; k++)
        send_item(fpca_pkg::OP_LOAD, fpca_pkg::INDEX_W'(k), rand_chunk_size(), 1'b0, tg);
      for (int n = 0; n < PHASE_LEN; n++) begin
        r = $urandom_range(99);
        if (r < 78)
          send_item(fpca_pkg::OP_REQUEST, fpca_pkg::INDEX_W'($urandom),
                    rand_request_size(), 1'b0, tg);
        else if (r < 86)
          send_item(fpca_pkg::OP_LOAD, fpca_pkg::INDEX_W'($urandom),
                    rand_chunk_size(), 1'b0, tg);
        else if (r < 94)
          send_item(fpca_pkg::OP_RESTART, fpca_pkg::INDEX_W'($urandom),
                    fpca_pkg::FIELD_W'($urandom), 1'b0, tg);
        else
          send_item(OP_SPARE, fpca_pkg::INDEX_W'($urandom),
                    fpca_pkg::FIELD_W'($urandom), 1'b0, tg);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    sender_pct = 0;
    guard = 0;
    while (grant_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
    if (grant_q.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time, grant_q.size());
      err_cnt++;
    end

    if (err_cnt == 0)
      $display("fit_policy_chunk_allocator verification clean");
    else
      $display("fit_policy_chunk_allocator verification failed");
    $finish;
  end

endmodule
